// ===== design/c816alu_pkg.sv =====
// ----------------------------------------------------------------------------
// c816alu_pkg: shared types and constants for the 65816-style binary ALU
// Operation codes, width masks and the item structures of both channels.
// ----------------------------------------------------------------------------
package c816alu_pkg;

   typedef enum logic [3:0] {
      MODE_ADC = 4'd0,
      MODE_SBC = 4'd1,
      MODE_ORA = 4'd2,
      MODE_AND = 4'd3,
      MODE_EOR = 4'd4,
      MODE_CMP = 4'd5,
      MODE_CPX = 4'd6,
      MODE_CPY = 4'd7,
      MODE_INC = 4'd8,
      MODE_DEC = 4'd9,
      MODE_INX = 4'd10,
      MODE_INY = 4'd11,
      MODE_DEX = 4'd12,
      MODE_DEY = 4'd13,
      MODE_XBA = 4'd14
   } alu_mode_type;

   localparam logic [15:0] MASK_NARROW = 16'h00FF;
   localparam logic [15:0] MASK_WIDE   = 16'hFFFF;

   typedef struct packed {
      alu_mode_type mode;
      logic [15:0]  acc_in;
      logic [15:0]  x_in;
      logic [15:0]  y_in;
      logic [15:0]  operand;
      logic         carry_in;
      logic         overflow_in;
      logic         mem_narrow;
      logic         index_narrow;
      logic         acc_target;
   } req_item_type;

   typedef struct packed {
      logic [15:0] acc_out;
      logic [15:0] x_out;
      logic [15:0] y_out;
      logic [15:0] mem_out;
      logic        mem_write;
      logic        n_flag;
      logic        v_flag;
      logic        z_flag;
      logic        c_flag;
   } rsp_item_type;

endpackage

// ===== design/c816alu_core.sv =====
// ----------------------------------------------------------------------------
// c816alu_core: combinational ALU and flag network
// Computes the new registers, memory write-back value and N, V, Z, C flags
// for one item at 8-bit or 16-bit width.
// ----------------------------------------------------------------------------
module c816alu_core
   import c816alu_pkg::*;
(
   input  req_item_type item,
   output rsp_item_type result
);

   always_comb begin
      logic [15:0] mmask;
      logic [15:0] xmask;
      logic [15:0] a;
      logic [15:0] m;
      logic [15:0] b;
      logic [15:0] r;
      logic [15:0] o;
      logic [15:0] src;
      logic [15:0] res;
      logic [16:0] sum;
      logic [16:0] diff;
      logic        narrow;
      logic        nz_valid;

      mmask    = item.mem_narrow ? MASK_NARROW : MASK_WIDE;
      xmask    = item.index_narrow ? MASK_NARROW : MASK_WIDE;
      a        = item.acc_in & mmask;
      m        = item.operand & mmask;
      b        = (item.mode == MODE_SBC) ? (~m & mmask) : m;
      r        = ((item.mode == MODE_CPX || item.mode == MODE_INX || item.mode == MODE_DEX)
                  ? item.x_in : item.y_in) & xmask;
      o        = item.operand & xmask;
      src      = item.acc_target ? a : m;
      sum      = 17'(a) + 17'(b) + 17'(item.carry_in);
      diff     = 17'(a) - 17'(m);
      res      = '0;
      narrow   = item.mem_narrow;
      nz_valid = 1'b1;

      result.acc_out   = item.acc_in;
      result.x_out     = item.x_in;
      result.y_out     = item.y_in;
      result.mem_out   = '0;
      result.mem_write = 1'b0;
      result.v_flag    = item.overflow_in;
      result.c_flag    = item.carry_in;

      case (item.mode)
         MODE_ADC, MODE_SBC: begin
            res           = sum[15:0] & mmask;
            result.c_flag = item.mem_narrow ? sum[8] : sum[16];
            result.v_flag = item.mem_narrow ? ((a[7] ^ res[7]) & (b[7] ^ res[7]))
                                            : ((a[15] ^ res[15]) & (b[15] ^ res[15]));
         end
         MODE_ORA: res = a | m;
         MODE_AND: res = a & m;
         MODE_EOR: res = a ^ m;
         MODE_CMP: begin
            res           = diff[15:0] & mmask;
            result.c_flag = ~diff[16];
         end
         MODE_CPX, MODE_CPY: begin
            diff          = 17'(r) - 17'(o);
            res           = diff[15:0] & xmask;
            result.c_flag = ~diff[16];
            narrow        = item.index_narrow;
         end
         MODE_INC, MODE_DEC: begin
            res = ((item.mode == MODE_INC) ? src + 16'd1 : src - 16'd1) & mmask;
            if (!item.acc_target) begin
               result.mem_out   = res;
               result.mem_write = 1'b1;
            end
         end
         MODE_INX, MODE_INY, MODE_DEX, MODE_DEY: begin
            res    = ((item.mode == MODE_INX || item.mode == MODE_INY)
                      ? r + 16'd1 : r - 16'd1) & xmask;
            narrow = item.index_narrow;
            if (item.mode == MODE_INX || item.mode == MODE_DEX) begin
               result.x_out = res;
            end else begin
               result.y_out = res;
            end
         end
         MODE_XBA: begin
            result.acc_out = {item.acc_in[7:0], item.acc_in[15:8]};
            res            = {8'h00, item.acc_in[15:8]};
            narrow         = 1'b1;
         end
         default: nz_valid = 1'b0;
      endcase

      if (item.mode == MODE_ADC || item.mode == MODE_SBC || item.mode == MODE_ORA ||
          item.mode == MODE_AND || item.mode == MODE_EOR ||
          ((item.mode == MODE_INC || item.mode == MODE_DEC) && item.acc_target)) begin
         result.acc_out = item.mem_narrow ? {item.acc_in[15:8], res[7:0]} : res;
      end

      result.n_flag = nz_valid & (narrow ? res[7] : res[15]);
      result.z_flag = nz_valid & (res == 16'h0000);
   end

endmodule

// ===== design/cpu65816_alu_flags.sv =====
// ----------------------------------------------------------------------------
// cpu65816_alu_flags: binary-mode ALU of a 65816-style processor
// An accepted item is held in the input register and is then loaded into the
// result register once that register is free; the result register shows it.
// Throughput: one item per cycle while rsp_stall is low; the input and result
// registers let one new item enter while a finished result waits under rsp_stall.
// Reset: synchronous reset empties both registers; payload is not cleared.
// ----------------------------------------------------------------------------
module cpu65816_alu_flags
   import c816alu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_mode,
   input  logic [15:0] req_acc_in,
   input  logic [15:0] req_x_in,
   input  logic [15:0] req_y_in,
   input  logic [15:0] req_operand,
   input  logic        req_carry_in,
   input  logic        req_overflow_in,
   input  logic        req_mem_narrow,
   input  logic        req_index_narrow,
   input  logic        req_acc_target,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_acc_out,
   output logic [15:0] rsp_x_out,
   output logic [15:0] rsp_y_out,
   output logic [15:0] rsp_mem_out,
   output logic        rsp_mem_write,
   output logic        rsp_n_flag,
   output logic        rsp_v_flag,
   output logic        rsp_z_flag,
   output logic        rsp_c_flag
);

   req_item_type req_ff;
   req_item_type req_in;
   logic         req_valid_ff;
   logic         req_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_comb;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         rsp_ready;
   logic         rsp_load;
   logic         req_ready;
   logic         req_take;

   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = req_valid_ff && rsp_ready;
   assign req_ready = !req_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign req_stall = !req_ready;

   always_comb begin
      req_in.mode         = alu_mode_type'(req_mode);
      req_in.acc_in       = req_acc_in;
      req_in.x_in         = req_x_in;
      req_in.y_in         = req_y_in;
      req_in.operand      = req_operand;
      req_in.carry_in     = req_carry_in;
      req_in.overflow_in  = req_overflow_in;
      req_in.mem_narrow   = req_mem_narrow;
      req_in.index_narrow = req_index_narrow;
      req_in.acc_target   = req_acc_target;
   end

   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = rsp_ready ? req_valid_ff : rsp_valid_ff;

   c816alu_core u_core (
      .item   (req_ff),
      .result (rsp_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_comb;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_acc_out   = rsp_ff.acc_out;
   assign rsp_x_out     = rsp_ff.x_out;
   assign rsp_y_out     = rsp_ff.y_out;
   assign rsp_mem_out   = rsp_ff.mem_out;
   assign rsp_mem_write = rsp_ff.mem_write;
   assign rsp_n_flag    = rsp_ff.n_flag;
   assign rsp_v_flag    = rsp_ff.v_flag;
   assign rsp_z_flag    = rsp_ff.z_flag;
   assign rsp_c_flag    = rsp_ff.c_flag;

   // The input side stalls only while the input register holds an item.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff)
      else $error("input stalled with an empty input register");

   // A result without a memory write carries a zero write-back value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mem_write |-> rsp_mem_out == 16'h0000)
      else $error("memory value present without a memory write");

   // A narrow logic operation keeps the high byte of the accumulator.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && req_ff.mem_narrow &&
      (req_ff.mode == MODE_ORA || req_ff.mode == MODE_AND || req_ff.mode == MODE_EOR)
      |=> rsp_acc_out[15:8] == $past(req_ff.acc_in[15:8]))
      else $error("narrow accumulator lost its high byte");

   // A narrow index increment clears the high byte of X.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load && req_ff.index_narrow && req_ff.mode == MODE_INX
      |=> rsp_x_out[15:8] == 8'h00)
      else $error("narrow index kept a high byte");

   // Every result loaded into the result register is presented as valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid)
      else $error("result lost after loading");

endmodule

// ===== tb/sv/cpu65816_alu_flags_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65816_alu_flags_tb: self-checking testbench for the binary-mode ALU
// Drives operations on the request channel with random gaps and stalls the
// result channel at random. Every accepted item is run through a local model
// of the ALU, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module cpu65816_alu_flags_tb;
   import c816alu_pkg::*;

   localparam logic [3:0] MODE_NONE = 4'd15;

   typedef struct packed {
      logic [3:0]  mode;
      logic [15:0] acc;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] operand;
      logic        carry;
      logic        overflow;
      logic        mem_narrow;
      logic        index_narrow;
      logic        acc_target;
   } alu_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_mode = '0;
   logic [15:0] req_acc_in = '0;
   logic [15:0] req_x_in = '0;
   logic [15:0] req_y_in = '0;
   logic [15:0] req_operand = '0;
   logic        req_carry_in = 1'b0;
   logic        req_overflow_in = 1'b0;
   logic        req_mem_narrow = 1'b0;
   logic        req_index_narrow = 1'b0;
   logic        req_acc_target = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_acc_out;
   logic [15:0] rsp_x_out;
   logic [15:0] rsp_y_out;
   logic [15:0] rsp_mem_out;
   logic        rsp_mem_write;
   logic        rsp_n_flag;
   logic        rsp_v_flag;
   logic        rsp_z_flag;
   logic        rsp_c_flag;

   rsp_item_type pending_results[$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           results_seen = 0;
   int           mode_count[16];
   bit           send_idle = 1'b1;
   bit           recv_idle = 1'b1;

   cpu65816_alu_flags dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_acc_in       (req_acc_in),
      .req_x_in         (req_x_in),
      .req_y_in         (req_y_in),
      .req_operand      (req_operand),
      .req_carry_in     (req_carry_in),
      .req_overflow_in  (req_overflow_in),
      .req_mem_narrow   (req_mem_narrow),
      .req_index_narrow (req_index_narrow),
      .req_acc_target   (req_acc_target),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_x_out        (rsp_x_out),
      .rsp_y_out        (rsp_y_out),
      .rsp_mem_out      (rsp_mem_out),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_n_flag       (rsp_n_flag),
      .rsp_v_flag       (rsp_v_flag),
      .rsp_z_flag       (rsp_z_flag),
      .rsp_c_flag       (rsp_c_flag)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic rsp_item_type alu_predict(alu_op_type op);
      logic [15:0] wmask, smask, xmask, xsign;
      logic [15:0] a, m, b, r, o, src, res, sgn, msk;
      logic [16:0] sum;
      logic        nz_ok, acc_wr;
      rsp_item_type e;
      wmask = op.mem_narrow ? MASK_NARROW : MASK_WIDE;
      smask = op.mem_narrow ? 16'h0080 : 16'h8000;
      xmask = op.index_narrow ? MASK_NARROW : MASK_WIDE;
      xsign = op.index_narrow ? 16'h0080 : 16'h8000;
      a = op.acc & wmask;
      m = op.operand & wmask;
      e.acc_out = op.acc;
      e.x_out = op.x;
      e.y_out = op.y;
      e.mem_out = '0;
      e.mem_write = 1'b0;
      e.c_flag = op.carry;
      e.v_flag = op.overflow;
      res = '0;
      sgn = smask;
      msk = wmask;
      nz_ok = 1'b1;
      acc_wr = 1'b0;
      case (op.mode)
         MODE_ADC, MODE_SBC: begin
            b = (op.mode == MODE_ADC) ? m : (~m & wmask);
            sum = {1'b0, a} + {1'b0, b} + {16'd0, op.carry};
            res = sum[15:0] & wmask;
            e.c_flag = (sum > {1'b0, wmask});
            e.v_flag = |((a ^ res) & (b ^ res) & smask);
            acc_wr = 1'b1;
         end
         MODE_ORA: begin
            res = a | m;
            acc_wr = 1'b1;
         end
         MODE_AND: begin
            res = a & m;
            acc_wr = 1'b1;
         end
         MODE_EOR: begin
            res = a ^ m;
            acc_wr = 1'b1;
         end
         MODE_CMP: begin
            res = (a - m) & wmask;
            e.c_flag = (a >= m);
         end
         MODE_CPX, MODE_CPY: begin
            r = ((op.mode == MODE_CPX) ? op.x : op.y) & xmask;
            o = op.operand & xmask;
            res = (r - o) & xmask;
            e.c_flag = (r >= o);
            sgn = xsign;
            msk = xmask;
         end
         MODE_INC, MODE_DEC: begin
            src = op.acc_target ? a : m;
            res = ((op.mode == MODE_INC) ? src + 16'd1 : src - 16'd1) & wmask;
            if (op.acc_target) begin
               acc_wr = 1'b1;
            end else begin
               e.mem_out = res;
               e.mem_write = 1'b1;
            end
         end
         MODE_INX, MODE_INY, MODE_DEX, MODE_DEY: begin
            r = ((op.mode == MODE_INX || op.mode == MODE_DEX) ? op.x : op.y) & xmask;
            res = ((op.mode == MODE_INX || op.mode == MODE_INY) ? r + 16'd1 : r - 16'd1)
                  & xmask;
            if (op.mode == MODE_INX || op.mode == MODE_DEX) begin
               e.x_out = res;
            end else begin
               e.y_out = res;
            end
            sgn = xsign;
            msk = xmask;
         end
         MODE_XBA: begin
            e.acc_out = {op.acc[7:0], op.acc[15:8]};
            res = {8'h00, op.acc[15:8]};
            sgn = 16'h0080;
            msk = MASK_NARROW;
         end
         default: begin
            nz_ok = 1'b0;
         end
      endcase
      if (acc_wr) begin
         e.acc_out = op.mem_narrow ? {op.acc[15:8], res[7:0]} : res;
      end
      e.n_flag = nz_ok && |(res & sgn);
      e.z_flag = nz_ok && ((res & msk) == 16'd0);
      return e;
   endfunction

   // The flag bits are, from the top: carry, overflow, narrow memory, narrow index,
   // and accumulator target.
   function automatic alu_op_type make_op(logic [3:0] mode, logic [15:0] acc,
                                          logic [15:0] x, logic [15:0] y,
                                          logic [15:0] operand, logic [4:0] flags);
      alu_op_type op;
      op.mode = mode;
      op.acc = acc;
      op.x = x;
      op.y = y;
      op.operand = operand;
      op.carry = flags[4];
      op.overflow = flags[3];
      op.mem_narrow = flags[2];
      op.index_narrow = flags[1];
      op.acc_target = flags[0];
      return op;
   endfunction

   // Values near the width and sign boundaries turn up often.
   function automatic logic [15:0] random_word();
      logic [15:0] corner[8];
      corner = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h00FF, 16'h0080, 16'h007F,
                 16'h0100};
      if ($urandom_range(0, 3) == 0) begin
         return corner[3'($urandom_range(0, 7))];
      end
      return 16'($urandom);
   endfunction

   function automatic alu_op_type random_op();
      return make_op(4'($urandom_range(0, 15)), random_word(), random_word(),
                     random_word(), random_word(), 5'($urandom));
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic send_item(alu_op_type op);
      int gap;
      gap = send_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= op.mode;
      req_acc_in <= op.acc;
      req_x_in <= op.x;
      req_y_in <= op.y;
      req_operand <= op.operand;
      req_carry_in <= op.carry;
      req_overflow_in <= op.overflow;
      req_mem_narrow <= op.mem_narrow;
      req_index_narrow <= op.index_narrow;
      req_acc_target <= op.acc_target;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_results.push_back(alu_predict(op));
      mode_count[op.mode]++;
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin : result_checker
      rsp_item_type want;
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_acc_out, 16'h0);
            end else begin
               want = pending_results.pop_front();
               check_field("acc_out", rsp_acc_out, want.acc_out);
               check_field("x_out", rsp_x_out, want.x_out);
               check_field("y_out", rsp_y_out, want.y_out);
               check_field("mem_out", rsp_mem_out, want.mem_out);
               check_field("mem_write", 16'(rsp_mem_write), 16'(want.mem_write));
               check_field("n_flag", 16'(rsp_n_flag), 16'(want.n_flag));
               check_field("v_flag", 16'(rsp_v_flag), 16'(want.v_flag));
               check_field("z_flag", 16'(rsp_z_flag), 16'(want.z_flag));
               check_field("c_flag", 16'(rsp_c_flag), 16'(want.c_flag));
            end
            results_seen++;
            hold = recv_idle ? $urandom_range(0, 15) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic test_directed();
      send_item(make_op(MODE_ADC, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 5'b00000));
      send_item(make_op(MODE_ADC, 16'h7FFF, 16'h1111, 16'h2222, 16'h0001, 5'b00011));
      send_item(make_op(MODE_ADC, 16'h12FF, 16'hFFFF, 16'hFFFF, 16'hFF01, 5'b11100));
      send_item(make_op(MODE_SBC, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 5'b10000));
      send_item(make_op(MODE_SBC, 16'hAB00, 16'h0000, 16'h0000, 16'h0001, 5'b01111));
      send_item(make_op(MODE_ORA, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'b00000));
      send_item(make_op(MODE_AND, 16'hFF80, 16'h00FF, 16'hFF00, 16'hFFFF, 5'b11101));
      send_item(make_op(MODE_EOR, 16'hFFFF, 16'h0000, 16'h0000, 16'h5555, 5'b00000));
      send_item(make_op(MODE_CMP, 16'h1234, 16'h0000, 16'h0000, 16'h1234, 5'b01000));
      send_item(make_op(MODE_CMP, 16'hFF10, 16'h0000, 16'h0000, 16'h0020, 5'b10100));
      send_item(make_op(MODE_CPX, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 5'b10000));
      send_item(make_op(MODE_CPX, 16'h0000, 16'hFF7F, 16'h0000, 16'h0080, 5'b00010));
      send_item(make_op(MODE_CPY, 16'h0000, 16'h0000, 16'h8000, 16'h0001, 5'b01000));
      send_item(make_op(MODE_INC, 16'h34FF, 16'h0000, 16'h0000, 16'h0000, 5'b00101));
      send_item(make_op(MODE_INC, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 5'b11000));
      send_item(make_op(MODE_DEC, 16'h0000, 16'h0000, 16'h0000, 16'hABCD, 5'b00110));
      send_item(make_op(MODE_DEC, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'b00001));
      send_item(make_op(MODE_INX, 16'h0000, 16'h12FF, 16'h0000, 16'h0000, 5'b00010));
      send_item(make_op(MODE_INY, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 5'b11000));
      send_item(make_op(MODE_DEX, 16'h0000, 16'hAB00, 16'h0000, 16'h0000, 5'b00111));
      send_item(make_op(MODE_DEY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'b00000));
      send_item(make_op(MODE_XBA, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 5'b00000));
      send_item(make_op(MODE_XBA, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 5'b11111));
      send_item(make_op(MODE_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'b11111));
      send_item(make_op(MODE_NONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'b00000));
   endtask

   // Idling on each side is switched on and off in blocks of items.
   task automatic test_random_mix();
      for (int i = 0; i < 1000; i++) begin
         if (i % 100 == 0) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
         end
         send_item(random_op());
      end
   endtask

   task automatic test_back_to_back();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      for (int i = 0; i < 200; i++) begin
         send_item(random_op());
      end
   endtask

   task automatic test_drain_pauses();
      int burst;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      for (int i = 0; i < 225; i += burst) begin
         burst = $urandom_range(1, 8);
         for (int j = 0; j < burst; j++) begin
            send_item(random_op());
         end
         wait_for_results();
      end
   endtask

   initial begin : main
      int modes_hit;
      foreach (mode_count[i]) mode_count[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix();
      test_back_to_back();
      test_drain_pauses();
      wait_for_results();
      repeat (8) @(posedge clock);
      modes_hit = 0;
      foreach (mode_count[i]) begin
         if (mode_count[i] != 0) modes_hit++;
      end
      $display("Sent %0d operations covering %0d of 16 mode codes at both widths.",
               items_sent, modes_hit);
      $display("Compared %0d results with random gaps and stalls on both channels.",
               results_seen);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/c816alu_pkg.sv
design/c816alu_core.sv
design/cpu65816_alu_flags.sv
tb/sv/cpu65816_alu_flags_tb.sv
